// ----- design/r2fft_pkg.sv -----
// ----------------------------------------------------------------------------
// r2fft_pkg
// shared types, constants and the twiddle generator for the radix-2 fft
// ----------------------------------------------------------------------------
package r2fft_pkg;

  localparam int unsigned WORD_W = 32;
  localparam int unsigned OUT_W  = 27;
  localparam int unsigned BIN_W  = 10;
  localparam int unsigned LG_W   = 4;

  localparam logic [63:0] PI_Q30 = 64'd3373259426;
  localparam logic [63:0] ONE_Q30 = 64'd1 << 30;

  // taylor denominators (2n-1)(2n) and (2n)(2n+1)
  localparam logic [63:0] CosDen [1:8] = '{64'd2, 64'd12, 64'd30, 64'd56,
                                           64'd90, 64'd132, 64'd182, 64'd240};
  localparam logic [63:0] SinDen [1:8] = '{64'd6, 64'd20, 64'd42, 64'd72,
                                           64'd110, 64'd156, 64'd210, 64'd272};

  // butterfly datapath steps
  typedef enum logic [2:0] {
    STEP_NONE = 3'd0,
    STEP_LOAD = 3'd1,
    STEP_M0   = 3'd2,
    STEP_M1   = 3'd3,
    STEP_M2   = 3'd4,
    STEP_M3   = 3'd5,
    STEP_FIN  = 3'd6
  } step_e;

  typedef struct packed {
    logic  busy;
    step_e step;
  } bfly_ctrl_t;

  function automatic logic [15:0] to_q15(input logic [63:0] v);
    logic [63:0] q;
    q = (v + 64'd16384) >> 15;
    return (q > 64'd32767) ? 16'd32767 : q[15:0];
  endfunction

  // rom word for entry k of a table of 2**lg points: {-sin, cos}
  function automatic logic [31:0] tw_word(input int k, input int lg);
    logic [63:0] m2, oct, rem, x, x2, ct, st, cs, ss;
    logic [15:0] c, s, re, sn;
    m2  = 64'd1 << lg;
    oct = (64'(k) << 3) >> lg;
    rem = (64'(k) << 3) & (m2 - 64'd1);
    if (oct[0]) rem = m2 - rem;
    x  = (PI_Q30 * rem) >> (lg + 2);
    x2 = (x * x) >> 30;
    ct = ONE_Q30;
    st = x;
    cs = ONE_Q30;
    ss = x;
    for (int n = 1; n <= 8; n++) begin
      ct = ((ct * x2) >> 30) / CosDen[n];
      st = ((st * x2) >> 30) / SinDen[n];
      if (n % 2 == 1) begin
        cs = cs - ct;
        ss = ss - st;
      end else begin
        cs = cs + ct;
        ss = ss + st;
      end
    end
    c = to_q15(cs);
    s = to_q15(ss);
    case (oct[1:0])
      2'd0: begin re = c;       sn = s; end
      2'd1: begin re = s;       sn = c; end
      2'd2: begin re = 16'(-s); sn = c; end
      default: begin re = 16'(-c); sn = s; end
    endcase
    return {16'(-sn), re};
  endfunction

endpackage

// ----- design/radix2_fft_real_input.sv -----
// ----------------------------------------------------------------------------
// radix2_fft_real_input
// in-place radix-2 dit fft over real samples, read out as real parts of bins
// ----------------------------------------------------------------------------
// timing: a load beat is written to the ram as it is taken; a fetch reads the
//   ram, then fills the result register; the last load starts the transform,
//   each butterfly going read, operand load, four products on the one shared
//   multiplier, finish, two writes through the single ram write port; one
//   load beat per cycle unless a result waits; a fetch only after it is taken
// reset: async active low, length register 10, loading with zero counts
// ----------------------------------------------------------------------------
module radix2_fft_real_input #(
  parameter int unsigned MAX_POINTS  = 1024,
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [r2fft_pkg::LG_W-1:0]    cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          kind_i,
  input  logic signed [SAMPLE_BITS-1:0] sample_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [r2fft_pkg::OUT_W-1:0] real_part_o,
  output logic [r2fft_pkg::BIN_W-1:0]   bin_index_o,
  output logic                          last_o
);
  import r2fft_pkg::*;

  // largest power of two not above MAX_POINTS
  localparam int unsigned ROM_LG = $clog2(MAX_POINTS + 1) - 1;
  localparam int unsigned AW     = ROM_LG;
  localparam int unsigned TW_AW  = (ROM_LG > 1) ? ROM_LG - 1 : 1;

  // sequencer states
  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_RDOUT = 4'd1;
  localparam logic [3:0] ST_BRD   = 4'd2;
  localparam logic [3:0] ST_BLD   = 4'd3;
  localparam logic [3:0] ST_M0    = 4'd4;
  localparam logic [3:0] ST_M1    = 4'd5;
  localparam logic [3:0] ST_M2    = 4'd6;
  localparam logic [3:0] ST_M3    = 4'd7;
  localparam logic [3:0] ST_FIN   = 4'd8;
  localparam logic [3:0] ST_WP    = 4'd9;
  localparam logic [3:0] ST_WQ    = 4'd10;

  localparam logic PH_LOAD = 1'b0;
  localparam logic PH_READ = 1'b1;

  logic [3:0]      state_q, state_d;
  logic            phase_q, phase_d;
  logic [LG_W-1:0] lg_q, lg_d;
  logic [AW-1:0]   cnt_q, cnt_d;
  logic [4:0]      stage_q, stage_d;
  logic [AW-1:0]   bf_q, bf_d;
  logic            out_valid_q, out_valid_d;
  logic [OUT_W-1:0] real_q;
  logic [BIN_W-1:0] bin_q;
  logic            last_q;

  // effective log2 length, clamped between 1 and what the twiddle table covers
  logic [4:0]      lgu;
  logic [AW-1:0]   nmask;
  logic [AW-1:0]   rev_cnt;
  logic [AW-1:0]   load_addr;
  logic [AW-1:0]   span;
  logic [AW-1:0]   low_i;
  logic [AW-1:0]   p_addr, q_addr;
  logic [AW-1:0]   tw_full;
  logic            accept;
  logic            cnt_last;
  logic            bf_last;
  logic            stage_last;

  // ram and datapath hookup
  logic            we;
  logic [AW-1:0]   waddr;
  logic [63:0]     wdata;
  logic [AW-1:0]   raddr_a;
  logic [63:0]     rdata_a, rdata_b;
  logic [31:0]     tw_data;
  logic [63:0]     p_res, q_res;
  bfly_ctrl_t      bctrl;
  logic signed [31:0] rd_re;

  always_comb begin
    if (lg_q < LG_W'(1)) begin
      lgu = 5'd1;
    end else if (5'(lg_q) > 5'(ROM_LG)) begin
      lgu = 5'(ROM_LG);
    end else begin
      lgu = 5'(lg_q);
    end
  end

  assign nmask    = AW'((33'd1 << lgu) - 33'd1);
  assign cnt_last = (cnt_q == nmask);

  // bit reversal at load time: sample k goes to address rev(k)
  always_comb begin
    for (int b = 0; b < AW; b++) begin
      rev_cnt[b] = cnt_q[AW-1-b];
    end
  end
  assign load_addr = rev_cnt >> (5'(ROM_LG) - lgu);

  // butterfly addressing from stage and butterfly counter
  assign span    = AW'(1) << stage_q;
  assign low_i   = bf_q & (span - AW'(1));
  assign p_addr  = ((bf_q >> stage_q) << (stage_q + 5'd1)) | low_i;
  assign q_addr  = p_addr | span;
  assign tw_full = low_i << (5'(ROM_LG) - 5'd1 - stage_q);
  assign bf_last    = (bf_q == (nmask >> 1));
  assign stage_last = (stage_q == lgu - 5'd1);

  assign in_ready_o = (state_q == ST_IDLE) && !out_valid_q;
  assign accept     = in_valid_i && in_ready_o;

  assign raddr_a = (state_q == ST_IDLE) ? cnt_q : p_addr;

  always_comb begin
    case (state_q)
      ST_BLD:  bctrl = '{busy: 1'b1, step: STEP_LOAD};
      ST_M0:   bctrl = '{busy: 1'b1, step: STEP_M0};
      ST_M1:   bctrl = '{busy: 1'b1, step: STEP_M1};
      ST_M2:   bctrl = '{busy: 1'b1, step: STEP_M2};
      ST_M3:   bctrl = '{busy: 1'b1, step: STEP_M3};
      ST_FIN:  bctrl = '{busy: 1'b1, step: STEP_FIN};
      default: bctrl = '{busy: 1'b0, step: STEP_NONE};
    endcase
  end

  // ram write mux: load beats, then the two halves of each butterfly
  always_comb begin
    we    = 1'b0;
    waddr = load_addr;
    wdata = {32'd0, 32'(sample_i)};
    case (state_q)
      ST_IDLE: we = accept && !kind_i && (phase_q == PH_LOAD);
      ST_WP: begin
        we    = 1'b1;
        waddr = p_addr;
        wdata = p_res;
      end
      ST_WQ: begin
        we    = 1'b1;
        waddr = q_addr;
        wdata = q_res;
      end
      default: ;
    endcase
  end

  // sequencer
  always_comb begin
    state_d     = state_q;
    phase_d     = phase_q;
    lg_d        = lg_q;
    cnt_d       = cnt_q;
    stage_d     = stage_q;
    bf_d        = bf_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (!kind_i && phase_q == PH_LOAD) begin
            if (cnt_last) begin
              // last sample kicks off the transform
              cnt_d   = '0;
              stage_d = '0;
              bf_d    = '0;
              state_d = ST_BRD;
            end else begin
              cnt_d = cnt_q + AW'(1);
            end
          end else if (kind_i && phase_q == PH_READ) begin
            state_d = ST_RDOUT;
            if (cnt_last) begin
              cnt_d   = '0;
              phase_d = PH_LOAD;
            end else begin
              cnt_d = cnt_q + AW'(1);
            end
          end
        end
      end
      ST_RDOUT: begin
        out_valid_d = 1'b1;
        state_d     = ST_IDLE;
      end
      ST_BRD: state_d = ST_BLD;
      ST_BLD: state_d = ST_M0;
      ST_M0:  state_d = ST_M1;
      ST_M1:  state_d = ST_M2;
      ST_M2:  state_d = ST_M3;
      ST_M3:  state_d = ST_FIN;
      ST_FIN: state_d = ST_WP;
      ST_WP:  state_d = ST_WQ;
      ST_WQ: begin
        if (bf_last) begin
          bf_d = '0;
          if (stage_last) begin
            phase_d = PH_READ;
            state_d = ST_IDLE;
          end else begin
            stage_d = stage_q + 5'd1;
            state_d = ST_BRD;
          end
        end else begin
          bf_d    = bf_q + AW'(1);
          state_d = ST_BRD;
        end
      end
      default: state_d = ST_IDLE;
    endcase
    // a length write restarts the block
    if (cfg_we_i) begin
      lg_d    = cfg_wdata_i;
      phase_d = PH_LOAD;
      cnt_d   = '0;
      state_d = ST_IDLE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      phase_q     <= PH_LOAD;
      lg_q        <= LG_W'(10);
      cnt_q       <= '0;
      stage_q     <= '0;
      bf_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      lg_q        <= lg_d;
      cnt_q       <= cnt_d;
      stage_q     <= stage_d;
      bf_q        <= bf_d;
      out_valid_q <= out_valid_d;
    end
  end

  // result register: index at the fetch, saturated value once ram data lands
  assign rd_re = rdata_a[31:0];

  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && accept) begin
      bin_q  <= BIN_W'(cnt_q);
      last_q <= cnt_last;
    end
    if (state_q == ST_RDOUT) begin
      if (rd_re > 32'sd67108863) begin
        real_q <= {1'b0, {(OUT_W-1){1'b1}}};
      end else if (rd_re < -32'sd67108864) begin
        real_q <= {1'b1, {(OUT_W-1){1'b0}}};
      end else begin
        real_q <= rd_re[OUT_W-1:0];
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign real_part_o = real_q;
  assign bin_index_o = bin_q;
  assign last_o      = last_q;

  r2fft_ram #(
    .AW(AW)
  ) u_ram (
    .clk_i     (clk_i),
    .we_i      (we),
    .waddr_i   (waddr),
    .wdata_i   (wdata),
    .raddr_a_i (raddr_a),
    .raddr_b_i (q_addr),
    .rdata_a_o (rdata_a),
    .rdata_b_o (rdata_b)
  );

  r2fft_twiddle_rom #(
    .ROM_LG(ROM_LG),
    .TW_AW (TW_AW)
  ) u_rom (
    .clk_i  (clk_i),
    .addr_i (tw_full[TW_AW-1:0]),
    .data_o (tw_data)
  );

  r2fft_bfly u_bfly (
    .clk_i  (clk_i),
    .ctrl_i (bctrl),
    .a_i    (rdata_a),
    .b_i    (rdata_b),
    .w_i    (tw_data),
    .p_o    (p_res),
    .q_o    (q_res)
  );

  // a result only appears right after a ram read for a fetch
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q) == ST_RDOUT)
    else $error("result without a fetch");

  // the final butterfly hands the block over to read-out
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WQ && bf_last && stage_last && !cfg_we_i)
      |=> (phase_q == PH_READ && state_q == ST_IDLE && cnt_q == '0))
    else $error("transform end did not enter read-out");

  // the result register is free whenever a fetch is in flight
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_RDOUT |-> !out_valid_q)
    else $error("fetch overran pending result");

endmodule

// ----- design/r2fft_twiddle_rom.sv -----
// ----------------------------------------------------------------------------
// r2fft_twiddle_rom
// constant twiddle table with registered read, {-sin, cos} per word
// ----------------------------------------------------------------------------
module r2fft_twiddle_rom #(
  parameter int unsigned ROM_LG = 10,
  parameter int unsigned TW_AW  = 9
) (
  input  logic             clk_i,
  input  logic [TW_AW-1:0] addr_i,
  output logic [31:0]      data_o
);
  import r2fft_pkg::*;

  localparam int unsigned TwDepth = (1 << ROM_LG) / 2;

  logic [31:0] rom_w [TwDepth];
  logic [31:0] data_q;

  for (genvar g = 0; g < TwDepth; g++) begin : g_rom
    localparam logic [31:0] Word = tw_word(g, ROM_LG);
    assign rom_w[g] = Word;
  end

  always_ff @(posedge clk_i) begin
    data_q <= rom_w[addr_i];
  end

  assign data_o = data_q;

endmodule

// ----- design/r2fft_ram.sv -----
// ----------------------------------------------------------------------------
// r2fft_ram
// work memory, one write port and two registered read ports, {imag, real}
// ----------------------------------------------------------------------------
module r2fft_ram #(
  parameter int unsigned AW = 10
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [63:0]   wdata_i,
  input  logic [AW-1:0] raddr_a_i,
  input  logic [AW-1:0] raddr_b_i,
  output logic [63:0]   rdata_a_o,
  output logic [63:0]   rdata_b_o
);
  logic [63:0] mem [1 << AW];
  logic [63:0] rdata_a_q;
  logic [63:0] rdata_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_a_q <= mem[raddr_a_i];
    rdata_b_q <= mem[raddr_b_i];
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

// ----- design/r2fft_bfly.sv -----
// ----------------------------------------------------------------------------
// r2fft_bfly
// butterfly datapath on one shared 32x16 multiplier, four products per beat
// ----------------------------------------------------------------------------
module r2fft_bfly (
  input  logic                  clk_i,
  input  r2fft_pkg::bfly_ctrl_t ctrl_i,
  input  logic [63:0]           a_i,
  input  logic [63:0]           b_i,
  input  logic [31:0]           w_i,
  output logic [63:0]           p_o,
  output logic [63:0]           q_o
);
  import r2fft_pkg::*;

  logic signed [31:0] ar_q, ai_q, br_q, bi_q;
  logic signed [15:0] wr_q, wi_q;
  logic signed [31:0] mx;
  logic signed [15:0] my;
  logic signed [47:0] prod_q, acc_q;
  logic signed [48:0] sum;
  logic signed [48:0] rnd;
  logic signed [31:0] tr_q, ti_q;

  always_comb begin
    mx = br_q;
    my = wr_q;
    case (ctrl_i.step)
      STEP_M0: begin mx = br_q; my = wr_q; end
      STEP_M1: begin mx = bi_q; my = wi_q; end
      STEP_M2: begin mx = br_q; my = wi_q; end
      STEP_M3: begin mx = bi_q; my = wr_q; end
      default: begin mx = br_q; my = wr_q; end
    endcase
  end

  // real part subtracts, imaginary part adds
  assign sum = (ctrl_i.step == STEP_M2) ? (49'(acc_q) - 49'(prod_q))
                                        : (49'(acc_q) + 49'(prod_q));
  assign rnd = (sum + 49'sd16384) >>> 15;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.busy) begin
      case (ctrl_i.step)
        STEP_LOAD: begin
          ar_q <= a_i[31:0];
          ai_q <= a_i[63:32];
          br_q <= b_i[31:0];
          bi_q <= b_i[63:32];
          wr_q <= w_i[15:0];
          wi_q <= w_i[31:16];
        end
        STEP_M0: prod_q <= mx * my;
        STEP_M1: begin
          acc_q  <= prod_q;
          prod_q <= mx * my;
        end
        STEP_M2: begin
          tr_q   <= rnd[31:0];
          prod_q <= mx * my;
        end
        STEP_M3: begin
          acc_q  <= prod_q;
          prod_q <= mx * my;
        end
        STEP_FIN: ti_q <= rnd[31:0];
        default: ;
      endcase
    end
  end

  assign p_o = {ai_q + ti_q, ar_q + tr_q};
  assign q_o = {ai_q - ti_q, ar_q - tr_q};

endmodule

// ----- sim/radix2_fft_real_input_tb.sv -----
// ----------------------------------------------------------------------------
// radix2_fft_real_input_tb
// self-checking bench: real sample blocks go in, bin real parts are predicted
// by a bit-true fixed-point fft and compared beat by beat at the output
// ----------------------------------------------------------------------------
module radix2_fft_real_input_tb;

  localparam int unsigned MaxPts  = 1024;
  localparam int unsigned RomLg   = 10;
  localparam logic [63:0] PiQ30   = 64'd3373259426;
  localparam logic [63:0] OneQ30  = 64'd1 << 30;
  localparam bit          KindLoad  = 1'b0;
  localparam bit          KindFetch = 1'b1;

  typedef struct {
    bit               kind;
    logic signed [15:0] sample;
  } beat_t;

  typedef struct {
    logic signed [26:0] re;
    logic [9:0]         idx;
    bit                 last;
  } bin_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [r2fft_pkg::LG_W-1:0] cfg_wdata_i = '0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic kind_i = 1'b0;
  logic signed [15:0] sample_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic signed [r2fft_pkg::OUT_W-1:0] real_part_o;
  logic [r2fft_pkg::BIN_W-1:0] bin_index_o;
  logic last_o;

  radix2_fft_real_input u_top (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i, .in_valid_i, .in_ready_o,
    .kind_i, .sample_i, .out_valid_o, .out_ready_i, .real_part_o,
    .bin_index_o, .last_o
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // stimulus and expectation stores
  beat_t stim_q[$];
  bin_t  bins_q[$];
  int    errors = 0;
  int    beats_sent = 0;
  int    beats_taken = 0;
  int    bins_seen = 0;
  int    transforms = 0;
  int    send_pct = 24;  // sender idle chance per cycle
  int    recv_pct = 81;  // receiver idle chance per cycle
  bit    in_taken = 1'b0;
  bit    stall_req = 1'b0;
  bit    stall_done = 1'b0;
  int    stall_cnt = 0;

  // predictor state
  int      work_re [MaxPts];
  int      work_im [MaxPts];
  shortint tw_cos  [MaxPts/2];
  shortint tw_nsin [MaxPts/2];
  int      fft_lg = 10;
  int      n_loaded = 0;
  int      n_read = 0;
  bit      reading = 1'b0;

  // q1.15 cos/sin of pi/4 * r/m, taylor series in q2.30
  task automatic octant_trig(input logic [63:0] r, input logic [63:0] m,
                             output logic [15:0] c, output logic [15:0] s);
    logic [63:0] x, x2, ct, st, cs, ss, q;
    x  = (PiQ30 * r) / (64'd4 * m);
    x2 = (x * x) >> 30;
    ct = OneQ30;
    st = x;
    cs = OneQ30;
    ss = x;
    for (int k = 1; k <= 8; k++) begin
      ct = ((ct * x2) >> 30) / 64'((2 * k - 1) * (2 * k));
      st = ((st * x2) >> 30) / 64'((2 * k) * (2 * k + 1));
      if (k % 2 == 1) begin
        cs -= ct;
        ss -= st;
      end else begin
        cs += ct;
        ss += st;
      end
    end
    q = (cs + 64'd16384) >> 15;
    c = (q > 64'd32767) ? 16'd32767 : q[15:0];
    q = (ss + 64'd16384) >> 15;
    s = (q > 64'd32767) ? 16'd32767 : q[15:0];
  endtask

  task automatic build_twiddles();
    int oct, rem;
    logic [15:0] c, s, re, sn;
    for (int k = 0; k < MaxPts / 2; k++) begin
      oct = (8 * k) / MaxPts;
      rem = (8 * k) % MaxPts;
      if (oct % 2 == 1) rem = MaxPts - rem;
      octant_trig(64'(rem), 64'(MaxPts), c, s);
      case (oct)
        0: begin re = c; sn = s; end
        1: begin re = s; sn = c; end
        2: begin re = -s; sn = c; end
        default: begin re = -c; sn = s; end
      endcase
      tw_cos[k]  = re;
      tw_nsin[k] = -sn;
    end
  endtask

  function automatic int used_lg();
    return (fft_lg < 1) ? 1 : (fft_lg > RomLg) ? RomLg : fft_lg;
  endfunction

  task automatic run_transform(input int lg);
    int n, romstep, j, x, tmp, span, step, p, q;
    longint wr, wi, ar, ai, br, bi, tr, ti;
    n = 1 << lg;
    romstep = 1 << (RomLg - lg);
    for (int i = 0; i < n; i++) begin
      j = 0;
      x = i;
      for (int b = 0; b < lg; b++) begin
        j = (j << 1) | (x & 1);
        x >>= 1;
      end
      if (j > i) begin
        tmp = work_re[i]; work_re[i] = work_re[j]; work_re[j] = tmp;
        tmp = work_im[i]; work_im[i] = work_im[j]; work_im[j] = tmp;
      end
    end
    for (int st = 0; st < lg; st++) begin
      span = 1 << st;
      step = n / (2 * span);
      for (int base = 0; base < n; base += 2 * span) begin
        for (int i = 0; i < span; i++) begin
          p = base + i;
          q = p + span;
          wr = tw_cos[(i * step * romstep) % (MaxPts / 2)];
          wi = tw_nsin[(i * step * romstep) % (MaxPts / 2)];
          br = work_re[q]; bi = work_im[q];
          ar = work_re[p]; ai = work_im[p];
          tr = (br * wr - bi * wi + 64'sd16384) >>> 15;
          ti = (br * wi + bi * wr + 64'sd16384) >>> 15;
          work_re[p] = int'(ar + tr); work_im[p] = int'(ai + ti);
          work_re[q] = int'(ar - tr); work_im[q] = int'(ai - ti);
        end
      end
    end
  endtask

  // advance the predictor by one accepted input beat
  task automatic predict_beat(input beat_t b);
    int n, idx;
    longint v;
    bin_t e;
    n = 1 << used_lg();
    if (b.kind == KindLoad) begin
      if (reading) return;
      work_re[n_loaded] = int'(b.sample);
      work_im[n_loaded] = 0;
      n_loaded++;
      if (n_loaded >= n) begin
        run_transform(used_lg());
        transforms++;
        reading = 1'b1;
        n_read = 0;
      end
    end else begin
      if (!reading) return;
      idx = n_read;
      v = work_re[idx];
      if (v > 64'sd67108863) v = 64'sd67108863;
      if (v < -64'sd67108864) v = -64'sd67108864;
      e.re = 27'(v);
      e.idx = 10'(idx);
      e.last = (idx == n - 1);
      bins_q.push_back(e);
      n_read++;
      if (n_read >= n) begin
        reading = 1'b0;
        n_loaded = 0;
        n_read = 0;
      end
    end
  endtask

  // input side: acceptance seen at the rising edge feeds the predictor
  always @(posedge clk_i) begin
    beat_t b;
    in_taken <= in_valid_i && in_ready_o;
    if (rst_ni && in_valid_i && in_ready_o) begin
      b.kind = kind_i;
      b.sample = sample_i;
      beats_taken++;
      predict_beat(b);
    end
  end

  // idle mix by accepted beats: receiver idles more, then sender, then neither
  always @(negedge clk_i) begin
    if (beats_taken < 383) begin
      send_pct <= 24;
      recv_pct <= 81;
    end else if (beats_taken < 766) begin
      send_pct <= 81;
      recv_pct <= 24;
    end else begin
      send_pct <= 0;
      recv_pct <= 0;
    end
  end

  // driver: holds a beat until taken, otherwise pulls the next one or idles
  always @(negedge clk_i) begin
    beat_t b;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (in_valid_i && !in_taken) begin
      // waiting for ready, payload stays put
    end else if (stim_q.size() != 0 && $urandom_range(99) >= send_pct) begin
      b = stim_q.pop_front();
      in_valid_i <= 1'b1;
      kind_i <= b.kind;
      sample_i <= b.sample;
    end else begin
      in_valid_i <= 1'b0;
    end
  end

  // receiver: random stalls plus one long hold-off on request, counted
  // only while a result is waiting
  always @(negedge clk_i) begin
    if (stall_req && !stall_done) begin
      out_ready_i <= 1'b0;
      if (out_valid_o) stall_cnt <= stall_cnt + 1;
      if (stall_cnt >= 400) stall_done <= 1'b1;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_pct);
    end
  end

  // monitor: each output beat against the oldest expected bin
  always @(posedge clk_i) begin
    bin_t e;
    if (rst_ni && out_valid_o && out_ready_i) begin
      bins_seen++;
      if (bins_q.size() == 0) begin
        errors++;
        $display("%0t unexpected bin: got re %0d idx %0d last %0d", $time,
                 real_part_o, bin_index_o, last_o);
      end else begin
        e = bins_q.pop_front();
        if (real_part_o !== e.re || bin_index_o !== e.idx || last_o !== e.last) begin
          errors++;
          $display("%0t bin mismatch: expected re %0d idx %0d last %0d, got re %0d idx %0d last %0d",
                   $time, e.re, e.idx, e.last, real_part_o, bin_index_o, last_o);
        end
      end
    end
  end

  task automatic push_beat(input bit kind, input logic signed [15:0] s);
    beat_t b;
    b.kind = kind;
    b.sample = s;
    stim_q.push_back(b);
    beats_sent++;
  endtask

  function automatic logic signed [15:0] rand_sample();
    case ($urandom_range(7))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2: return 16'($urandom_range(63)) - 16'sd32;
      default: return 16'($urandom);
    endcase
  endfunction

  // sender waits until the block has nothing left to deliver
  task automatic drain();
    do @(negedge clk_i);
    while (stim_q.size() != 0 || in_valid_i || bins_q.size() != 0);
    repeat (40) @(negedge clk_i);
  endtask

  // length register write while idle; aborts any partial block
  task automatic set_length(input int lg);
    @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_wdata_i = 4'(lg);
    fft_lg = lg;
    reading = 1'b0;
    n_loaded = 0;
    n_read = 0;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  // one block: loads then fetches, with stray ignored beats and optional cuts
  task automatic run_block(input int lg, input bit dc_full);
    int n, cut_load, cut_read;
    n = 1 << ((lg < 1) ? 1 : (lg > RomLg) ? RomLg : lg);
    cut_load = n;
    cut_read = n;
    if ($urandom_range(9) == 0) cut_load = $urandom_range(n - 1);
    else if ($urandom_range(9) == 0) cut_read = $urandom_range(n - 1);
    for (int i = 0; i < cut_load; i++) begin
      if ($urandom_range(15) == 0) push_beat(KindFetch, rand_sample());
      push_beat(KindLoad, dc_full ? 16'sh8000 : rand_sample());
    end
    if (cut_load == n) begin
      for (int i = 0; i < cut_read; i++) begin
        if (i > 0 && $urandom_range(15) == 0) push_beat(KindLoad, rand_sample());
        push_beat(KindFetch, rand_sample());
      end
    end
    drain();
  endtask

  // full length block, only the first bins read before the run ends
  task automatic run_long(input int reads);
    for (int i = 0; i < MaxPts; i++) push_beat(KindLoad, rand_sample());
    for (int i = 0; i < reads; i++) push_beat(KindFetch, rand_sample());
    drain();
  endtask

  initial begin
    int lg, r, rand_start;
    build_twiddles();
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: reset length, fetch while loading, then abort by a write
    push_beat(KindFetch, 16'sh0000);
    push_beat(KindLoad, 16'sh7fff);
    push_beat(KindLoad, 16'sh8000);
    drain();
    set_length(1);
    // two-point extremes, a spare fetch after the block is done
    push_beat(KindLoad, 16'sh7fff);
    push_beat(KindLoad, 16'sh8000);
    push_beat(KindFetch, 16'sh0000);
    push_beat(KindFetch, 16'sh0000);
    push_beat(KindFetch, 16'sh0000);
    drain();
    set_length(2);
    // four points with a load while reading
    push_beat(KindLoad, 16'sh0000);
    push_beat(KindLoad, 16'sh0001);
    push_beat(KindLoad, 16'shffff);
    push_beat(KindLoad, 16'sh4000);
    push_beat(KindFetch, 16'sh0000);
    push_beat(KindLoad, 16'sh1234);
    push_beat(KindFetch, 16'sh0000);
    push_beat(KindFetch, 16'sh0000);
    push_beat(KindFetch, 16'sh0000);
    drain();
    set_length(0);   // clamps to two points
    push_beat(KindLoad, 16'sh8000);
    push_beat(KindLoad, 16'sh8000);
    push_beat(KindFetch, 16'sh0000);
    push_beat(KindFetch, 16'sh0000);
    drain();

    // random short blocks
    rand_start = beats_sent;
    while (beats_sent - rand_start < 90) begin
      r = $urandom_range(19);
      lg = (r < 14) ? $urandom_range(4, 1) : 5;
      set_length(lg);
      run_block(lg, ($urandom_range(7) == 0));
    end

    // out-of-range length clamps to 1024 points; a long receiver hold-off
    // while fetches keep coming backs the output up into the input
    set_length(15);
    stall_req = 1'b1;
    run_long(48);

    $display("covered %0d input beats, %0d transforms, %0d bins checked",
             beats_sent, transforms, bins_seen);
    $display("lengths 2 to 32 and a clamped 1024, ignored beats, aborts and a long output stall");
    if (errors == 0) begin
      $display("radix2_fft_real_input test passed");
    end else begin
      $display("radix2_fft_real_input test failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    #20000000;
    $display("radix2_fft_real_input test failed");
    $finish;
  end

endmodule

// ----- radix2_fft_real_input.f -----
design/r2fft_pkg.sv
design/r2fft_twiddle_rom.sv
design/r2fft_ram.sv
design/r2fft_bfly.sv
design/radix2_fft_real_input.sv
sim/radix2_fft_real_input_tb.sv
